[rtl/core/spsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsm_pkg
// shared widths, grid extents and the queue entry type of the stencil block
// ----------------------------------------------------------------------------
package spsm_pkg;

    localparam int GRID_X = 16;
    localparam int GRID_Y = 16;
    localparam int GRID_Z = 16;

    localparam int COORD_W    = 4;
    localparam int COORD_SPAN = 2 ** COORD_W;
    localparam int ADDR_W     = 3 * COORD_W;
    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = 2 * DATA_W;
    // seven products need three guard bits, one spare
    localparam int ACC_W      = PROD_W + 4;

    // usable extent per axis, clipped to the coordinate range
    localparam logic [COORD_W:0] EXT_X = (COORD_W + 1)'(GRID_X < COORD_SPAN ? GRID_X : COORD_SPAN);
    localparam logic [COORD_W:0] EXT_Y = (COORD_W + 1)'(GRID_Y < COORD_SPAN ? GRID_Y : COORD_SPAN);
    localparam logic [COORD_W:0] EXT_Z = (COORD_W + 1)'(GRID_Z < COORD_SPAN ? GRID_Z : COORD_SPAN);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_STORE,
        KIND_QUERY,
        KIND_QUERY_OUT
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic [DATA_W-1:0]   vec;
        logic [DATA_W-1:0]   diag;
        logic [DATA_W-1:0]   px;
        logic [DATA_W-1:0]   py;
        logic [DATA_W-1:0]   pz;
    } entry_t;

endpackage

[rtl/core/spsm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsm_front
// request intake: classifies each beat and hands it to the queue
// ----------------------------------------------------------------------------
module spsm_front (
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic                         req_type,
    input  logic [spsm_pkg::COORD_W-1:0] cell_x,
    input  logic [spsm_pkg::COORD_W-1:0] cell_y,
    input  logic [spsm_pkg::COORD_W-1:0] cell_z,
    input  logic [spsm_pkg::DATA_W-1:0]  vector_value,
    input  logic [spsm_pkg::DATA_W-1:0]  diag_coef,
    input  logic [spsm_pkg::DATA_W-1:0]  plus_x_coef,
    input  logic [spsm_pkg::DATA_W-1:0]  plus_y_coef,
    input  logic [spsm_pkg::DATA_W-1:0]  plus_z_coef,
    input  logic                         queue_full,
    output logic                         push,
    output spsm_pkg::entry_t             entry
);
    import spsm_pkg::*;

    logic cell_in_grid;

    assign cell_in_grid = ({1'b0, cell_x} < EXT_X) && ({1'b0, cell_y} < EXT_Y)
                       && ({1'b0, cell_z} < EXT_Z);

    assign req_ready = !queue_full;

    // stores outside the grid are taken and dropped here
    assign push = req_valid && !queue_full && (req_type || cell_in_grid);

    always_comb
    begin
        entry.kind = !req_type ? KIND_STORE : (cell_in_grid ? KIND_QUERY : KIND_QUERY_OUT);
        entry.x    = cell_x;
        entry.y    = cell_y;
        entry.z    = cell_z;
        entry.vec  = vector_value;
        entry.diag = diag_coef;
        entry.px   = plus_x_coef;
        entry.py   = plus_y_coef;
        entry.pz   = plus_z_coef;
    end

endmodule

[rtl/core/spsm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsm_queue
// small fifo of classified requests between front and back
// ----------------------------------------------------------------------------
module spsm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  spsm_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output spsm_pkg::entry_t head
);
    import spsm_pkg::*;

    entry_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign full       = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + (QPTR_W + 1)'(1);
                2'b01:   count_reg <= count_reg - (QPTR_W + 1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[rtl/core/spsm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsm_back
// cell stores, stencil term sequencer, multiply-accumulate and result register
// ----------------------------------------------------------------------------
module spsm_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  spsm_pkg::entry_t            head,
    output logic                        pop,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [spsm_pkg::DATA_W-1:0] product_value,
    output logic                        saturated
);
    import spsm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } state_t;

    localparam logic [2:0] TERM_DIAG = 3'd0;
    localparam logic [2:0] TERM_XM   = 3'd1;
    localparam logic [2:0] TERM_XP   = 3'd2;
    localparam logic [2:0] TERM_YM   = 3'd3;
    localparam logic [2:0] TERM_YP   = 3'd4;
    localparam logic [2:0] TERM_ZM   = 3'd5;
    localparam logic [2:0] TERM_ZP   = 3'd6;

    logic [DATA_W-1:0] vec_mem  [2 ** ADDR_W];
    logic [DATA_W-1:0] diag_mem [2 ** ADDR_W];
    logic [DATA_W-1:0] px_mem   [2 ** ADDR_W];
    logic [DATA_W-1:0] py_mem   [2 ** ADDR_W];
    logic [DATA_W-1:0] pz_mem   [2 ** ADDR_W];

    logic [DATA_W-1:0] vec_rd_reg, diag_rd_reg, px_rd_reg, py_rd_reg, pz_rd_reg;

    state_t             state_reg, state_next;
    logic [2:0]         cnt_reg;
    logic               s1_valid_reg, s2_valid_reg, rsp_valid_reg;
    logic [2:0]         s1_term_reg;
    logic               s1_en_reg, s2_en_reg;
    logic [COORD_W-1:0] x_reg, y_reg, z_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, rnd;
    logic [DATA_W-1:0]  product_reg, sat_value, round_value;
    logic               saturated_reg, fits;

    logic               out_free, wr_en, start, load_zero, issue, finish;
    logic [ADDR_W-1:0]  wr_addr, cell_addr, vec_addr, coef_addr;
    logic               term_en;
    logic [DATA_W-1:0]  coef_sel;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign pop       = (state_reg == S_IDLE) && head_valid
                    && ((head.kind != KIND_QUERY_OUT) || out_free);
    assign wr_en     = pop && (head.kind == KIND_STORE);
    assign start     = pop && (head.kind == KIND_QUERY);
    assign load_zero = pop && (head.kind == KIND_QUERY_OUT);
    assign issue     = state_reg == S_ISSUE;
    assign finish    = (state_reg == S_DRAIN) && !s1_valid_reg && !s2_valid_reg && out_free;

    assign wr_addr   = {head.x, head.y, head.z};
    assign cell_addr = {x_reg, y_reg, z_reg};

    // addresses of the term being issued; -axis terms use the lower cell's coupling
    always_comb
    begin
        vec_addr  = cell_addr;
        coef_addr = cell_addr;
        term_en   = 1'b0;
        unique case (cnt_reg)
            TERM_DIAG:
            begin
                term_en = 1'b1;
            end
            TERM_XM:
            begin
                vec_addr  = {x_reg - COORD_W'(1), y_reg, z_reg};
                coef_addr = vec_addr;
                term_en   = x_reg != '0;
            end
            TERM_XP:
            begin
                vec_addr = {x_reg + COORD_W'(1), y_reg, z_reg};
                term_en  = ({1'b0, x_reg} + (COORD_W + 1)'(1)) < EXT_X;
            end
            TERM_YM:
            begin
                vec_addr  = {x_reg, y_reg - COORD_W'(1), z_reg};
                coef_addr = vec_addr;
                term_en   = y_reg != '0;
            end
            TERM_YP:
            begin
                vec_addr = {x_reg, y_reg + COORD_W'(1), z_reg};
                term_en  = ({1'b0, y_reg} + (COORD_W + 1)'(1)) < EXT_Y;
            end
            TERM_ZM:
            begin
                vec_addr  = {x_reg, y_reg, z_reg - COORD_W'(1)};
                coef_addr = vec_addr;
                term_en   = z_reg != '0;
            end
            TERM_ZP:
            begin
                vec_addr = {x_reg, y_reg, z_reg + COORD_W'(1)};
                term_en  = ({1'b0, z_reg} + (COORD_W + 1)'(1)) < EXT_Z;
            end
            default:
            begin
                term_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            vec_mem[wr_addr] <= head.vec;
        end
        vec_rd_reg <= vec_mem[vec_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            diag_mem[wr_addr] <= head.diag;
        end
        diag_rd_reg <= diag_mem[coef_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            px_mem[wr_addr] <= head.px;
        end
        px_rd_reg <= px_mem[coef_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            py_mem[wr_addr] <= head.py;
        end
        py_rd_reg <= py_mem[coef_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pz_mem[wr_addr] <= head.pz;
        end
        pz_rd_reg <= pz_mem[coef_addr];
    end

    always_comb
    begin
        unique case (s1_term_reg)
            TERM_DIAG:        coef_sel = diag_rd_reg;
            TERM_XM, TERM_XP: coef_sel = px_rd_reg;
            TERM_YM, TERM_YP: coef_sel = py_rd_reg;
            default:          coef_sel = pz_rd_reg;
        endcase
    end

    assign prod_next = $signed(coef_sel) * $signed(vec_rd_reg);

    // round half up at the q16.16 point, then clip to 32 bits
    assign rnd         = acc_reg + ACC_W'(2 ** (FRAC_W - 1));
    assign fits        = (&rnd[ACC_W-1:DATA_W+FRAC_W-1]) || !(|rnd[ACC_W-1:DATA_W+FRAC_W-1]);
    assign round_value = rnd[DATA_W+FRAC_W-1:FRAC_W];
    assign sat_value   = rnd[ACC_W-1] ? {1'b1, {(DATA_W - 1){1'b0}}}
                                      : {1'b0, {(DATA_W - 1){1'b1}}};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (cnt_reg == TERM_ZP)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= TERM_DIAG;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (start)
            begin
                cnt_reg <= TERM_DIAG;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            if (load_zero || finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            x_reg <= head.x;
            y_reg <= head.y;
            z_reg <= head.z;
        end
        s1_term_reg <= cnt_reg;
        s1_en_reg   <= term_en;
        prod_reg    <= prod_next;
        s2_en_reg   <= s1_en_reg;
        if (start)
        begin
            acc_reg <= '0;
        end
        else if (s2_valid_reg && s2_en_reg)
        begin
            acc_reg <= acc_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        if (load_zero)
        begin
            product_reg   <= '0;
            saturated_reg <= 1'b0;
        end
        else if (finish)
        begin
            product_reg   <= fits ? round_value : sat_value;
            saturated_reg <= !fits;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign product_value = product_reg;
    assign saturated     = saturated_reg;

endmodule

[rtl/core/seven_point_stencil_matvec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_point_stencil_matvec
// seven-point laplacian matrix-vector product over a 16x16x16 cell grid
// ----------------------------------------------------------------------------
// A store beat (req_type 0) writes one cell's vector element, diagonal
// coefficient and +x/+y/+z couplings; stores to cells outside the grid are
// dropped. A query beat (req_type 1) returns diag*v plus every in-grid
// neighbour's coupling times its value, where the -x/-y/-z couplings come from
// the lower neighbour's +axis coefficient. The seven q32.32 products are summed
// exactly, rounded half up to q16.16 and clipped to 32 bits, with saturated set
// on clipping; a query outside the grid returns zero. Query a cell only after
// every entry it touches was written: the stores have no reset. A store is
// written into the cell stores when the back end pops it from the queue.
// For a query the back end issues the seven terms, one term per cycle, set by
// the single read port of each cell store, then multiplies, accumulates and
// rounds the last term into the result register once that register is free;
// it pops no new request until then. A four-deep queue lets requests be
// taken while the back end works, and the result register holds a finished
// beat.
// ----------------------------------------------------------------------------
module seven_point_stencil_matvec (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic                                req_type,
    input  logic [spsm_pkg::COORD_W-1:0]        cell_x,
    input  logic [spsm_pkg::COORD_W-1:0]        cell_y,
    input  logic [spsm_pkg::COORD_W-1:0]        cell_z,
    input  logic signed [spsm_pkg::DATA_W-1:0]  vector_value,
    input  logic signed [spsm_pkg::DATA_W-1:0]  diag_coef,
    input  logic signed [spsm_pkg::DATA_W-1:0]  plus_x_coef,
    input  logic signed [spsm_pkg::DATA_W-1:0]  plus_y_coef,
    input  logic signed [spsm_pkg::DATA_W-1:0]  plus_z_coef,
    // result channel
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic signed [spsm_pkg::DATA_W-1:0]  product_value,
    output logic                                saturated
);
    import spsm_pkg::*;

    // front to queue
    logic   push;
    entry_t push_entry;
    logic   queue_full;

    // queue to back
    logic   head_valid;
    entry_t head;
    logic   pop;

    logic [DATA_W-1:0] product_bits;

    // classify each request beat: store, query, or query outside the grid
    spsm_front u_front (
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_type     (req_type),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .cell_z       (cell_z),
        .vector_value (vector_value),
        .diag_coef    (diag_coef),
        .plus_x_coef  (plus_x_coef),
        .plus_y_coef  (plus_y_coef),
        .plus_z_coef  (plus_z_coef),
        .queue_full   (queue_full),
        .push         (push),
        .entry        (push_entry)
    );

    // decouples intake from the term sequencer
    spsm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // cell stores, seven-term multiply-accumulate, rounding and clipping
    spsm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .product_value (product_bits),
        .saturated     (saturated)
    );

    assign product_value = $signed(product_bits);

endmodule

[bench/seven_point_stencil_matvec_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_point_stencil_matvec_tb
// self-checking bench for the seven-point stencil matrix-vector block
// ----------------------------------------------------------------------------
// Drives store and query beats through the valid/ready request channel and
// compares every result beat against an in-bench predictor that keeps its own
// copy of the five cell stores. A short table of directed beats covers the
// saturation limits, the rounding ties, the grid corners and ignored query
// data. After it, random store neighbourhoods are built and then queried, with
// some stray stores and abandoned neighbourhoods mixed in. Both channels idle
// at random, and the result side holds off once for a long time so that the
// request side backs up.
// ----------------------------------------------------------------------------
module seven_point_stencil_matvec_tb;

    import spsm_pkg::*;

    // request encoding on the req_type port
    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // q16.16 values used by the directed table
    localparam logic [DATA_W-1:0] Q_ULP      = 32'h0000_0001;
    localparam logic [DATA_W-1:0] Q_HALF     = 32'h0000_8000;
    localparam logic [DATA_W-1:0] Q_NEG_HALF = 32'hFFFF_8000;
    localparam logic [DATA_W-1:0] Q_ONE      = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_NEG_ONE  = 32'hFFFF_0000;
    localparam logic [DATA_W-1:0] Q_TWO      = 32'h0002_0000;
    localparam logic [DATA_W-1:0] Q_THREE    = 32'h0003_0000;
    localparam logic [DATA_W-1:0] Q_MAX      = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN      = 32'h8000_0000;
    localparam logic [DATA_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;

    // exact sum of seven q32.32 products, with rounding and clip limits
    localparam int                     SUM_W    = 2 * DATA_W + 4;
    localparam logic signed [SUM_W-1:0] HALF_LSB = 32768;
    localparam logic signed [SUM_W-1:0] SUM_MAX  = 2147483647;
    localparam logic signed [SUM_W-1:0] SUM_MIN  = ~SUM_MAX;

    localparam int CELLS        = 2 ** ADDR_W;
    localparam int RESET_CYCLES = 12;
    localparam int N_DIRECTED   = 23;
    localparam int RANDOM_BEATS = 1400;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 50;
    localparam int TIMEOUT_NS   = 3_000_000;

    typedef struct packed {
        logic                kind;
        logic [COORD_W-1:0]  x, y, z;
        logic [DATA_W-1:0]   vec, diag, px, py, pz;
        logic                has_want;
        logic [DATA_W-1:0]   want_value;
        logic                want_sat;
    } beat_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              sat;
    } product_t;

    logic                      clk;
    logic                      rst_n;
    logic                      req_valid;
    logic                      req_ready;
    logic                      req_type;
    logic [COORD_W-1:0]        cell_x;
    logic [COORD_W-1:0]        cell_y;
    logic [COORD_W-1:0]        cell_z;
    logic signed [DATA_W-1:0]  vector_value;
    logic signed [DATA_W-1:0]  diag_coef;
    logic signed [DATA_W-1:0]  plus_x_coef;
    logic signed [DATA_W-1:0]  plus_y_coef;
    logic signed [DATA_W-1:0]  plus_z_coef;
    logic                      rsp_valid;
    logic                      rsp_ready;
    logic signed [DATA_W-1:0]  product_value;
    logic                      saturated;

    // predictor copy of the cell stores, plus which cells were ever written
    logic [DATA_W-1:0] vec_mem  [CELLS];
    logic [DATA_W-1:0] diag_mem [CELLS];
    logic [DATA_W-1:0] px_mem   [CELLS];
    logic [DATA_W-1:0] py_mem   [CELLS];
    logic [DATA_W-1:0] pz_mem   [CELLS];
    bit                cell_written [CELLS];

    product_t          pending_products [$];
    logic [ADDR_W-1:0] queried_cells [$];
    product_t          oldest;
    int                mismatches;
    int                results_seen;
    int                beats_sent;
    bit                burst_mode;

    logic [DATA_W-1:0] corner_values [9] = '{
        32'h0, Q_ULP, ALL_ONES, Q_MAX, Q_MIN, Q_ONE, Q_NEG_ONE, Q_HALF, Q_NEG_HALF
    };

    // directed beats; a query with has_want set carries its own expected result
    // kind       x   y   z   vec          diag         px           py         pz
    //                                                          has_want value sat
    beat_t directed_beats [N_DIRECTED] = '{
        '{REQ_STORE, 0, 0, 0, Q_ONE, Q_TWO, 0, 0, 0, 0, 0, 0},
        '{REQ_STORE, 1, 0, 0, Q_ONE, 0, 0, 0, 0, 0, 0, 0},
        '{REQ_STORE, 0, 1, 0, Q_ONE, 0, 0, 0, 0, 0, 0, 0},
        '{REQ_STORE, 0, 0, 1, Q_ONE, 0, 0, 0, 0, 0, 0, 0},
        // only the diagonal term is nonzero
        '{REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1, Q_TWO, 0},
        // everything at full scale clips high
        '{REQ_STORE, 0, 0, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0},
        '{REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1, Q_MAX, 1},
        // most negative coefficient times largest value clips low
        '{REQ_STORE, 0, 0, 0, Q_MAX, Q_MIN, 0, 0, 0, 0, 0, 0},
        '{REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1, Q_MIN, 1},
        // exact half ulp rounds up
        '{REQ_STORE, 0, 0, 0, Q_ULP, Q_HALF, 0, 0, 0, 0, 0, 0},
        '{REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1, Q_ULP, 0},
        // minus half ulp rounds toward +inf, to zero
        '{REQ_STORE, 0, 0, 0, Q_ULP, Q_NEG_HALF, 0, 0, 0, 0, 0, 0},
        '{REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0},
        // min times min is the largest product
        '{REQ_STORE, 0, 0, 0, Q_MIN, Q_MIN, 0, 0, 0, 0, 0, 0},
        // data fields of a query are don't-care
        '{REQ_QUERY, 0, 0, 0, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
          1, Q_MAX, 1},
        // far corner: only the lower neighbours count, through their own coefs
        '{REQ_STORE, 14, 15, 15, Q_TWO, 0, Q_THREE, 0, 0, 0, 0, 0},
        '{REQ_STORE, 15, 14, 15, Q_ONE, 0, 0, Q_NEG_ONE, 0, 0, 0, 0},
        '{REQ_STORE, 15, 15, 14, Q_HALF, 0, 0, 0, Q_ONE, 0, 0, 0},
        '{REQ_STORE, 15, 15, 15, Q_ONE, 0, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0},
        '{REQ_QUERY, 15, 15, 15, 0, 0, 0, 0, 0, 1, 32'h0005_8000, 0},
        // mixed-sign fractions, checked by the predictor
        '{REQ_STORE, 0, 0, 0, 32'hFFFE_8000, 32'h0000_4000, 32'h0002_8000,
          32'hFFFF_C000, 32'h0000_0003, 0, 0, 0},
        '{REQ_STORE, 1, 0, 0, Q_THREE, 32'h1234_5678, ALL_ONES, 0, 0, 0, 0, 0},
        '{REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    seven_point_stencil_matvec uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_type      (req_type),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .cell_z        (cell_z),
        .vector_value  (vector_value),
        .diag_coef     (diag_coef),
        .plus_x_coef   (plus_x_coef),
        .plus_y_coef   (plus_y_coef),
        .plus_z_coef   (plus_z_coef),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .product_value (product_value),
        .saturated     (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic bit in_grid(input logic [COORD_W-1:0] x, y, z);
        return {1'b0, x} < EXT_X && {1'b0, y} < EXT_Y && {1'b0, z} < EXT_Z;
    endfunction

    // full-precision q32.32 product of two q16.16 words
    function automatic logic signed [SUM_W-1:0] fixed_mul(input logic [DATA_W-1:0] coef,
                                                          input logic [DATA_W-1:0] val);
        logic signed [SUM_W-1:0] a;
        logic signed [SUM_W-1:0] b;
        a = $signed(coef);
        b = $signed(val);
        return a * b;
    endfunction

    // diag*v plus each in-grid neighbour's coupling; lower neighbours
    // contribute through their own +axis coefficient and value
    function automatic product_t stencil_product(input logic [COORD_W-1:0] x, y, z);
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] rounded;
        product_t                p;
        p.value = '0;
        p.sat   = 1'b0;
        if (!in_grid(x, y, z))
            return p;
        acc = fixed_mul(diag_mem[{x, y, z}], vec_mem[{x, y, z}]);
        if (x > 0)
            acc += fixed_mul(px_mem[{x - 4'd1, y, z}], vec_mem[{x - 4'd1, y, z}]);
        if ({1'b0, x} + 5'd1 < EXT_X)
            acc += fixed_mul(px_mem[{x, y, z}], vec_mem[{x + 4'd1, y, z}]);
        if (y > 0)
            acc += fixed_mul(py_mem[{x, y - 4'd1, z}], vec_mem[{x, y - 4'd1, z}]);
        if ({1'b0, y} + 5'd1 < EXT_Y)
            acc += fixed_mul(py_mem[{x, y, z}], vec_mem[{x, y + 4'd1, z}]);
        if (z > 0)
            acc += fixed_mul(pz_mem[{x, y, z - 4'd1}], vec_mem[{x, y, z - 4'd1}]);
        if ({1'b0, z} + 5'd1 < EXT_Z)
            acc += fixed_mul(pz_mem[{x, y, z}], vec_mem[{x, y, z + 4'd1}]);
        // round half up to q16.16, then clip to 32 bits
        rounded = (acc + HALF_LSB) >>> FRAC_W;
        if (rounded > SUM_MAX)
        begin
            p.value = Q_MAX;
            p.sat   = 1'b1;
        end
        else if (rounded < SUM_MIN)
        begin
            p.value = Q_MIN;
            p.sat   = 1'b1;
        end
        else
            p.value = rounded[DATA_W-1:0];
        return p;
    endfunction

    // a query may only touch cells that were written
    function automatic bit cell_ok(input logic [COORD_W-1:0] x, y, z);
        bit ok;
        ok = in_grid(x, y, z) && cell_written[{x, y, z}];
        if (x > 0)
            ok &= cell_written[{x - 4'd1, y, z}];
        if ({1'b0, x} + 5'd1 < EXT_X)
            ok &= cell_written[{x + 4'd1, y, z}];
        if (y > 0)
            ok &= cell_written[{x, y - 4'd1, z}];
        if ({1'b0, y} + 5'd1 < EXT_Y)
            ok &= cell_written[{x, y + 4'd1, z}];
        if (z > 0)
            ok &= cell_written[{x, y, z - 4'd1}];
        if ({1'b0, z} + 5'd1 < EXT_Z)
            ok &= cell_written[{x, y, z + 4'd1}];
        return ok;
    endfunction

    // update the store copy on an accepted beat, or queue the product it owes
    function automatic void apply_beat(input beat_t b);
        logic [ADDR_W-1:0] a;
        product_t          p;
        a = {b.x, b.y, b.z};
        if (b.kind == REQ_STORE)
        begin
            if (in_grid(b.x, b.y, b.z))
            begin
                vec_mem[a]      = b.vec;
                diag_mem[a]     = b.diag;
                px_mem[a]       = b.px;
                py_mem[a]       = b.py;
                pz_mem[a]       = b.pz;
                cell_written[a] = 1'b1;
            end
        end
        else
        begin
            p = stencil_product(b.x, b.y, b.z);
            if (b.has_want)
            begin
                p.value = b.want_value;
                p.sat   = b.want_sat;
            end
            pending_products.push_back(p);
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // mix of full-range words, small signed fractions and corner values
    function automatic logic [DATA_W-1:0] random_fixed();
        logic signed [DATA_W-1:0] r;
        int                       pick;
        pick = $urandom_range(0, 99);
        r    = $urandom;
        if (pick < 30)
            return r;
        if (pick < 75)
            return r >>> $urandom_range(11, 23);
        return corner_values[$urandom_range(0, 8)];
    endfunction

    // biased toward the grid faces so edge handling sees plenty of traffic
    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            default: return COORD_W'($urandom_range(0, COORD_SPAN - 1));
        endcase
    endfunction

    function automatic beat_t random_beat(input logic kind,
                                          input logic [COORD_W-1:0] x, y, z);
        beat_t b;
        b.kind       = kind;
        b.x          = x;
        b.y          = y;
        b.z          = z;
        b.vec        = random_fixed();
        b.diag       = random_fixed();
        b.px         = random_fixed();
        b.py         = random_fixed();
        b.pz         = random_fixed();
        b.has_want   = 1'b0;
        b.want_value = '0;
        b.want_sat   = 1'b0;
        return b;
    endfunction

    function automatic int next_gap();
        int pick;
        if (burst_mode)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // present one request beat and hold it until accepted; valid stays high
    // across back-to-back beats so it is never dropped and raised in one step
    task automatic offer_beat(input beat_t b, input int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid    <= 1'b1;
        req_type     <= b.kind;
        cell_x       <= b.x;
        cell_y       <= b.y;
        cell_z       <= b.z;
        vector_value <= b.vec;
        diag_coef    <= b.diag;
        plus_x_coef  <= b.px;
        plus_y_coef  <= b.py;
        plus_z_coef  <= b.pz;
        do
            @(posedge clk);
        while (!req_ready);
        apply_beat(b);
        beats_sent++;
    endtask

    // write the cell and its in-grid neighbours; cells already written are
    // rewritten now and then; a partial pass drops cells at random
    task automatic store_neighbourhood(input logic [COORD_W-1:0] x, y, z,
                                       input bit partial);
        for (int k = 0; k < 7; k++)
        begin
            int nx;
            int ny;
            int nz;
            nx = x;
            ny = y;
            nz = z;
            case (k)
                1: nx--;
                2: nx++;
                3: ny--;
                4: ny++;
                5: nz--;
                6: nz++;
                default: ;
            endcase
            if (nx < 0 || ny < 0 || nz < 0)
                continue;
            if (nx >= int'(EXT_X) || ny >= int'(EXT_Y) || nz >= int'(EXT_Z))
                continue;
            if (partial && $urandom_range(0, 1) == 0)
                continue;
            if (cell_written[{4'(nx), 4'(ny), 4'(nz)}] && $urandom_range(0, 3) != 0)
                continue;
            offer_beat(random_beat(REQ_STORE, 4'(nx), 4'(ny), 4'(nz)), next_gap());
        end
    endtask

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    initial
    begin : stimulus
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
        logic [ADDR_W-1:0]  a;
        int                 flavor;
        rst_n        <= 1'b0;
        req_valid    <= 1'b0;
        req_type     <= REQ_STORE;
        cell_x       <= '0;
        cell_y       <= '0;
        cell_z       <= '0;
        vector_value <= '0;
        diag_coef    <= '0;
        plus_x_coef  <= '0;
        plus_y_coef  <= '0;
        plus_z_coef  <= '0;
        mismatches   = 0;
        beats_sent   = 0;
        burst_mode   = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_beats[i])
            offer_beat(directed_beats[i], next_gap());

        // random part: mostly build-then-query neighbourhoods, some stray
        // stores and some neighbourhoods that are never queried
        while (beats_sent < N_DIRECTED + RANDOM_BEATS)
        begin
            burst_mode = ($urandom_range(0, 3) == 0);
            flavor     = $urandom_range(0, 9);
            cx         = pick_coord();
            cy         = pick_coord();
            cz         = pick_coord();
            if (flavor == 0)
            begin
                repeat ($urandom_range(1, 4))
                    offer_beat(random_beat(REQ_STORE, COORD_W'($urandom),
                                           COORD_W'($urandom), COORD_W'($urandom)),
                               next_gap());
            end
            else if (flavor == 1)
                store_neighbourhood(cx, cy, cz, 1'b1);
            else
            begin
                store_neighbourhood(cx, cy, cz, 1'b0);
                if (cell_ok(cx, cy, cz))
                begin
                    offer_beat(random_beat(REQ_QUERY, cx, cy, cz), next_gap());
                    queried_cells.push_back({cx, cy, cz});
                end
                // revisit cells queried earlier; their entries stay written
                repeat ($urandom_range(0, 2))
                begin
                    a = queried_cells[$urandom_range(0, queried_cells.size() - 1)];
                    offer_beat(random_beat(REQ_QUERY, a[11:8], a[7:4], a[3:0]),
                               next_gap());
                end
            end
        end
        req_valid <= 1'b0;

        while (pending_products.size() != 0)
            @(posedge clk);
        // let any late store or stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    // random ready pattern, one long hold-off once traffic is flowing so the
    // internal queue fills and req_ready drops
    initial
    begin : result_sink
        int  span;
        int  pick;
        bit  held_off;
        rsp_ready <= 1'b0;
        held_off  = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held_off && results_seen >= 40)
            begin
                held_off = 1'b1;
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                rsp_ready <= 1'b1;
                span = $urandom_range(1, 8);
            end
            else if (pick < 90)
            begin
                rsp_ready <= 1'b0;
                span = $urandom_range(1, 3);
            end
            else if (pick < 95)
            begin
                rsp_ready <= 1'b0;
                span = $urandom_range(20, 60);
            end
            else
            begin
                // long stretch with no stall at all
                rsp_ready <= 1'b1;
                span = 100;
            end
            repeat (span) @(posedge clk);
        end
    end

    // every accepted result beat is matched against the oldest open product
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            results_seen++;
            if (pending_products.size() == 0)
            begin
                $error("unexpected result beat: product_value %h saturated %b",
                       product_value, saturated);
                mismatches++;
            end
            else
            begin
                oldest = pending_products.pop_front();
                if (product_value !== oldest.value)
                begin
                    $error("product_value: expected %h, got %h", oldest.value, product_value);
                    mismatches++;
                end
                if (saturated !== oldest.sat)
                begin
                    $error("saturated: expected %b, got %b", oldest.sat, saturated);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        results_seen = 0;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/spsm_pkg.sv
rtl/core/spsm_front.sv
rtl/core/spsm_queue.sv
rtl/core/spsm_back.sv
rtl/core/seven_point_stencil_matvec.sv
bench/seven_point_stencil_matvec_tb.sv
